### design/key_to_button_last_direction_priority_top_macros.svh
// Assertion helpers for the key mapper block.
`ifndef KEY_TO_BUTTON_LAST_DIRECTION_PRIORITY_TOP_MACROS_SVH
`define KEY_TO_BUTTON_LAST_DIRECTION_PRIORITY_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: cond holds, so prop holds.
`define KBLDP_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("kbldp check failed: same-cycle rule");

// Next-cycle implication: cond holds, so prop holds in the next cycle.
`define KBLDP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("kbldp check failed: next-cycle rule");

`else

`define KBLDP_ASSERT_SAME(label, clk, rst, cond, prop)
`define KBLDP_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

### design/kbldp_pkg.sv
package kbldp_pkg;

   localparam int KEY_CODE_W   = 8;
   localparam int BUTTON_W     = 9;
   localparam int DIR_COUNT    = 4;
   localparam int ACTION_COUNT = 4;
   localparam int DIR_IDX_W    = 2;
   localparam int COUNT_W      = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_INDEX_W  = 2;

   // Button positions in the button vector.
   localparam int BTN_FIRST_ACTION = 4;
   localparam int BTN_START        = 8;

   // Register indexes (byte address divided by four).
   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION_KEYCODES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTION_KEYCODES    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_KEYCODE      = 2'd2;

   // Reset key codes: W S A D, H J K L, carriage return.
   localparam logic [CSR_DATA_W-1:0] DIRECTION_KEYCODES_RESET = 32'h4441_5357;
   localparam logic [CSR_DATA_W-1:0] ACTION_KEYCODES_RESET    = 32'h4C4B_4A48;
   localparam logic [KEY_CODE_W-1:0] START_KEYCODE_RESET      = 8'h0D;

endpackage

### design/kbldp_if.sv
interface kbldp_req_if;
   logic                               valid;
   logic                               ready;
   logic                               device_is_keyboard;
   logic [kbldp_pkg::KEY_CODE_W-1:0]   key_code;
   logic                               key_down;

   modport source (output valid, device_is_keyboard, key_code, key_down, input ready);
   modport sink   (input valid, device_is_keyboard, key_code, key_down, output ready);
endinterface

interface kbldp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [kbldp_pkg::BUTTON_W-1:0]     button_state;

   modport source (output valid, button_state, input ready);
   modport sink   (input valid, button_state, output ready);
endinterface

### design/key_to_button_last_direction_priority_top.sv
// Keyboard to controller button mapper with last-direction priority.
// req_chan carries key press/release requests (device_is_keyboard, key_code,
// key_down); rsp_chan returns one button_state per request, in order.
// Nine key codes set over the APB-style port (direction codes at 0x0, action
// codes at 0x4, start code at 0x8) pick the buttons; on a code collision the
// later button wins, start highest. Write the port only while the block idles.
// Path: an accepted request passes through the input register and then the
// result register, whose contents show on rsp_chan until taken.
// Throughput: one request per cycle while rsp_chan is not stalled; the update of
// the held set and four-entry direction order list, done combinationally, sets it.
// Backpressure: while rsp_chan stalls, the result register holds, the input
// register holds one more request, and req_chan.ready drops only when both
// are full.
// Reset (synchronous, active high): clear held buttons and the order count,
// reload the default key codes and drop any request in flight.
`include "key_to_button_last_direction_priority_top_macros.svh"

module key_to_button_last_direction_priority_top (
   input  logic                                clock,
   input  logic                                reset,
   kbldp_req_if.sink                           req_chan,
   kbldp_rsp_if.source                         rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [kbldp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [kbldp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [kbldp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   // Configuration registers.
   logic [kbldp_pkg::CSR_DATA_W-1:0]  direction_keycodes_ff;
   logic [kbldp_pkg::CSR_DATA_W-1:0]  action_keycodes_ff;
   logic [kbldp_pkg::KEY_CODE_W-1:0]  start_keycode_ff;
   logic [kbldp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic                              csr_write;

   // Input register.
   logic                              s1_valid_ff;
   logic                              s1_keyboard_ff;
   logic [kbldp_pkg::KEY_CODE_W-1:0]  s1_key_code_ff;
   logic                              s1_key_down_ff;

   // Tracking state.
   logic [kbldp_pkg::BUTTON_W-1:0]    held_ff;
   logic [kbldp_pkg::BUTTON_W-1:0]    held_in;
   logic [kbldp_pkg::DIR_IDX_W-1:0]   order_ff [kbldp_pkg::DIR_COUNT];
   logic [kbldp_pkg::DIR_IDX_W-1:0]   order_in [kbldp_pkg::DIR_COUNT];
   logic [kbldp_pkg::COUNT_W-1:0]     count_ff;
   logic [kbldp_pkg::COUNT_W-1:0]     count_in;

   // Result register.
   logic                              rsp_valid_ff;
   logic [kbldp_pkg::BUTTON_W-1:0]    button_state_ff;
   logic [kbldp_pkg::BUTTON_W-1:0]    button_state_in;

   // Update datapath.
   logic                              advance;
   logic [kbldp_pkg::BUTTON_W-1:0]    key_match;
   logic [kbldp_pkg::BUTTON_W-1:0]    key_mask;
   logic [kbldp_pkg::DIR_COUNT-1:0]   pressed;
   logic [kbldp_pkg::DIR_COUNT-1:0]   released;
   logic [kbldp_pkg::DIR_IDX_W-1:0]   dir_idx;
   logic [kbldp_pkg::COUNT_W-1:0]     push_base;
   logic [kbldp_pkg::COUNT_W-1:0]     keep_count;
   logic [kbldp_pkg::DIR_COUNT-1:0]   head_onehot;

   // ---------------------------------------------------------------------
   // Configuration port: index from the word address, low bits ignored.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = paddr[kbldp_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_keycodes_ff <= kbldp_pkg::DIRECTION_KEYCODES_RESET;
         action_keycodes_ff    <= kbldp_pkg::ACTION_KEYCODES_RESET;
         start_keycode_ff      <= kbldp_pkg::START_KEYCODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            kbldp_pkg::REG_DIRECTION_KEYCODES: direction_keycodes_ff <= pwdata;
            kbldp_pkg::REG_ACTION_KEYCODES:    action_keycodes_ff    <= pwdata;
            kbldp_pkg::REG_START_KEYCODE:
               start_keycode_ff <= pwdata[kbldp_pkg::KEY_CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         kbldp_pkg::REG_DIRECTION_KEYCODES: prdata = direction_keycodes_ff;
         kbldp_pkg::REG_ACTION_KEYCODES:    prdata = action_keycodes_ff;
         kbldp_pkg::REG_START_KEYCODE:
            prdata = {{(kbldp_pkg::CSR_DATA_W-kbldp_pkg::KEY_CODE_W){1'b0}},
                      start_keycode_ff};
         default:                           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: the result register frees up when empty or taken; the
   // input register moves on whenever the result register can take it.
   // ---------------------------------------------------------------------
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_keyboard_ff <= req_chan.device_is_keyboard;
         s1_key_code_ff <= req_chan.key_code;
         s1_key_down_ff <= req_chan.key_down;
      end
   end

   // ---------------------------------------------------------------------
   // Key lookup: compare against all nine codes, keep the highest match so
   // a later button overrides an earlier one on a shared code.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++) begin
         key_match[i] = direction_keycodes_ff[8*i +: 8] == s1_key_code_ff;
      end
      for (int i = 0; i < kbldp_pkg::ACTION_COUNT; i++) begin
         key_match[kbldp_pkg::BTN_FIRST_ACTION + i] =
            action_keycodes_ff[8*i +: 8] == s1_key_code_ff;
      end
      key_match[kbldp_pkg::BTN_START] = start_keycode_ff == s1_key_code_ff;

      key_mask = '0;
      for (int i = 0; i < kbldp_pkg::BUTTON_W; i++) begin
         if (key_match[i]) begin
            key_mask    = '0;
            key_mask[i] = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Held set and direction order update. At most one direction changes
   // per request, so push and remove never happen together.
   // ---------------------------------------------------------------------
   always_comb begin
      if (!s1_keyboard_ff) begin
         held_in = held_ff;
      end else if (s1_key_down_ff) begin
         held_in = held_ff | key_mask;
      end else begin
         held_in = held_ff & ~key_mask;
      end

      pressed  = held_in[kbldp_pkg::DIR_COUNT-1:0] & ~held_ff[kbldp_pkg::DIR_COUNT-1:0];
      released = held_ff[kbldp_pkg::DIR_COUNT-1:0] & ~held_in[kbldp_pkg::DIR_COUNT-1:0];

      dir_idx = '0;
      for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++) begin
         if (pressed[i] || released[i]) begin
            dir_idx = kbldp_pkg::DIR_IDX_W'(i);
         end
      end

      // Push: shift the live entries down one place, drop the oldest when full.
      push_base = (count_ff >= kbldp_pkg::COUNT_W'(kbldp_pkg::DIR_COUNT)) ?
                  kbldp_pkg::COUNT_W'(kbldp_pkg::DIR_COUNT - 1) : count_ff;
      keep_count = '0;
      for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++) begin
         order_in[i] = order_ff[i];
      end
      count_in = count_ff;

      if (|pressed) begin
         for (int i = 1; i < kbldp_pkg::DIR_COUNT; i++) begin
            if (kbldp_pkg::COUNT_W'(i) <= push_base) begin
               order_in[i] = order_ff[i-1];
            end
         end
         order_in[0] = dir_idx;
         count_in    = push_base + 1'b1;
      end else if (|released) begin
         // Remove: compact the live entries that differ from the released one.
         for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++) begin
            if (kbldp_pkg::COUNT_W'(i) < count_ff && order_ff[i] != dir_idx) begin
               order_in[keep_count[kbldp_pkg::DIR_IDX_W-1:0]] = order_ff[i];
               keep_count = keep_count + 1'b1;
            end
         end
         count_in = keep_count;
      end

      // Report non-direction buttons plus the newest held direction only.
      head_onehot = (count_in != '0) ?
                    (kbldp_pkg::DIR_COUNT'(1) << order_in[0]) : '0;
      button_state_in = {held_in[kbldp_pkg::BUTTON_W-1:kbldp_pkg::DIR_COUNT], head_onehot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         count_ff <= '0;
      end else if (advance && s1_valid_ff) begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++) begin
            order_ff[i] <= order_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         button_state_ff <= button_state_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.button_state = button_state_ff;

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------
   `KBLDP_ASSERT_SAME(a_count_tracks_held, clock, reset, 1'b1,
      $countones(held_ff[kbldp_pkg::DIR_COUNT-1:0]) == 32'(count_ff))
   `KBLDP_ASSERT_SAME(a_head_is_held, clock, reset, count_ff != '0,
      held_ff[order_ff[0]])
   `KBLDP_ASSERT_SAME(a_one_direction_out, clock, reset, rsp_valid_ff,
      $onehot0(button_state_ff[kbldp_pkg::DIR_COUNT-1:0]))
   `KBLDP_ASSERT_NEXT(a_stall_freezes_state, clock, reset,
      rsp_valid_ff && !rsp_chan.ready, $stable(held_ff) && $stable(count_ff))

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // Cycles without any handshake before the run is declared hung. The
   // longest legal quiet stretch is one request gap or result stall plus the
   // pass through the input and result registers and a register access, so this is ample.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 160;
   localparam int PHASE_COUNT      = 8;

   localparam logic [kbldp_pkg::BUTTON_W-1:0] DIR_BITS =
      kbldp_pkg::BUTTON_W'((1 << kbldp_pkg::DIR_COUNT) - 1);

   typedef enum int {
      UP_BTN, DOWN_BTN, LEFT_BTN, RIGHT_BTN,
      A_BTN, B_BTN, C_BTN, D_BTN, START_BTN
   } button_type;

   typedef struct packed {
      logic                              keyboard;
      logic [kbldp_pkg::KEY_CODE_W-1:0]  code;
      logic                              down;
   } key_event_type;

   logic                              clock   = 1'b0;
   logic                              reset   = 1'b1;
   logic                              psel    = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite  = 1'b0;
   logic [kbldp_pkg::CSR_ADDR_W-1:0]  paddr   = '0;
   logic [kbldp_pkg::CSR_DATA_W-1:0]  pwdata  = '0;
   logic [kbldp_pkg::CSR_DATA_W-1:0]  prdata;
   logic                              pready;

   kbldp_req_if req_bus ();
   kbldp_rsp_if rsp_bus ();

   key_to_button_last_direction_priority_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow copy of the key code registers, as last written.
   logic [kbldp_pkg::CSR_DATA_W-1:0]  dir_codes   = kbldp_pkg::DIRECTION_KEYCODES_RESET;
   logic [kbldp_pkg::CSR_DATA_W-1:0]  act_codes   = kbldp_pkg::ACTION_KEYCODES_RESET;
   logic [kbldp_pkg::KEY_CODE_W-1:0]  start_code  = kbldp_pkg::START_KEYCODE_RESET;

   // Shadow of the held buttons and of the most-recent-first direction list.
   logic [kbldp_pkg::BUTTON_W-1:0]    held_buttons = '0;
   logic [kbldp_pkg::DIR_IDX_W-1:0]   dir_recent [kbldp_pkg::DIR_COUNT];
   logic [kbldp_pkg::COUNT_W-1:0]     dir_held_cnt = '0;

   key_event_type                     pending_events [$];
   key_event_type                     offered_event;
   logic [kbldp_pkg::BUTTON_W-1:0]    expected_buttons [$];
   logic [kbldp_pkg::BUTTON_W-1:0]    want_buttons;
   bit                                key_held [256];

   bit  offering     = 1'b0;
   int  req_gap      = 0;
   int  rsp_stall    = 0;
   int  req_calm     = 0;
   int  rsp_calm     = 0;
   int  idle_cycles  = 0;
   int  error_count  = 0;

   always #5 clock = ~clock;

   // Decode a key code; later buttons override earlier ones, start last.
   function automatic logic [kbldp_pkg::BUTTON_W-1:0] key_mask(
      logic [kbldp_pkg::KEY_CODE_W-1:0] code);
      logic [kbldp_pkg::BUTTON_W-1:0] m;
      m = '0;
      for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++)
         if (dir_codes[8*i +: 8] == code) m = kbldp_pkg::BUTTON_W'(1) << i;
      for (int i = 0; i < kbldp_pkg::ACTION_COUNT; i++)
         if (act_codes[8*i +: 8] == code)
            m = kbldp_pkg::BUTTON_W'(1) << (kbldp_pkg::BTN_FIRST_ACTION + i);
      if (start_code == code) m = kbldp_pkg::BUTTON_W'(1) << kbldp_pkg::BTN_START;
      return m;
   endfunction

   // Advance the shadow state by one request and return the button word it yields.
   function automatic logic [kbldp_pkg::BUTTON_W-1:0] apply_key_event(key_event_type ev);
      logic [kbldp_pkg::BUTTON_W-1:0] m, old_dirs, pressed, released, result;
      int n, j;
      if (ev.keyboard) begin
         m = key_mask(ev.code);
         old_dirs = held_buttons & DIR_BITS;
         held_buttons = ev.down ? (held_buttons | m) : (held_buttons & ~m);
         pressed  = held_buttons & DIR_BITS & ~old_dirs;
         released = old_dirs & ~(held_buttons & DIR_BITS);
         for (int i = 0; i < kbldp_pkg::DIR_COUNT; i++) begin
            if (pressed[i]) begin
               // Push to the front; a full list loses its oldest entry.
               n = (dir_held_cnt < kbldp_pkg::DIR_COUNT) ? dir_held_cnt
                                                         : kbldp_pkg::DIR_COUNT - 1;
               for (int k = n; k > 0; k--) dir_recent[k] = dir_recent[k-1];
               dir_recent[0] = kbldp_pkg::DIR_IDX_W'(i);
               dir_held_cnt = kbldp_pkg::COUNT_W'(n + 1);
            end else if (released[i]) begin
               // Squeeze the released direction out, keep the rest in order.
               j = 0;
               for (int k = 0; k < dir_held_cnt; k++)
                  if (dir_recent[k] != i) begin
                     dir_recent[j] = dir_recent[k];
                     j++;
                  end
               dir_held_cnt = kbldp_pkg::COUNT_W'(j);
            end
         end
      end
      result = held_buttons & ~DIR_BITS;
      if (dir_held_cnt != 0) result[dir_recent[0]] = 1'b1;
      return result;
   endfunction

   // Key code that the current setting assigns to a button.
   function automatic logic [kbldp_pkg::KEY_CODE_W-1:0] button_key(int idx);
      if (idx < kbldp_pkg::BTN_FIRST_ACTION) return dir_codes[8*idx +: 8];
      if (idx < kbldp_pkg::BTN_START)
         return act_codes[8*(idx - kbldp_pkg::BTN_FIRST_ACTION) +: 8];
      return start_code;
   endfunction

   // Pause length: mostly none, some short, a few long, and now and then a
   // calm stretch with no pauses at all.
   function automatic int pick_pause(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A word of four key codes drawn from a narrow range, so that they often collide.
   function automatic logic [kbldp_pkg::CSR_DATA_W-1:0] crowded_codes();
      logic [kbldp_pkg::CSR_DATA_W-1:0] w;
      for (int b = 0; b < 4; b++) w[8*b +: 8] = 8'h30 + 8'($urandom_range(0, 5));
      return w;
   endfunction

   task automatic queue_event(logic kbd, logic [kbldp_pkg::KEY_CODE_W-1:0] code,
                              logic down);
      key_event_type ev;
      ev.keyboard = kbd;
      ev.code     = code;
      ev.down     = down;
      if (kbd) key_held[code] = down;
      pending_events.push_back(ev);
   endtask

   // Mostly well-formed press/release traffic on the mapped keys, mostly
   // toggling each key, with repeats, stray codes and non-keyboard noise.
   task automatic queue_random(int count);
      int roll;
      logic [kbldp_pkg::KEY_CODE_W-1:0] code;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            queue_event(1'b0, 8'($urandom), 1'($urandom));
         end else if (roll < 14) begin
            queue_event(1'b1, 8'($urandom), 1'($urandom));
         end else begin
            code = button_key($urandom_range(0, 8));
            queue_event(1'b1, code, key_held[code] ? ($urandom_range(0, 9) == 0)
                                                   : ($urandom_range(0, 9) != 0));
         end
      end
   endtask

   // Write one register, then read it back.
   task automatic csr_write(logic [kbldp_pkg::CSR_INDEX_W-1:0] index,
                            logic [kbldp_pkg::CSR_DATA_W-1:0] value);
      logic [kbldp_pkg::CSR_DATA_W-1:0] want;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         kbldp_pkg::REG_DIRECTION_KEYCODES: dir_codes  = value;
         kbldp_pkg::REG_ACTION_KEYCODES:    act_codes  = value;
         kbldp_pkg::REG_START_KEYCODE:      start_code = value[kbldp_pkg::KEY_CODE_W-1:0];
         default: ;
      endcase
      want = (index == kbldp_pkg::REG_START_KEYCODE) ? {24'b0, value[7:0]} : value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         error_count++;
         $display("%0t: register %0d readback, expected %h, actual %h",
                  $time, index, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Hold until every request has gone in and every result has come out,
   // then let the pipeline settle.
   task automatic wait_idle();
      while (pending_events.size() != 0 || offering || expected_buttons.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: predict on acceptance, then offer the next queued
   // request once its gap has run out.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_buttons.push_back(apply_key_event(offered_event));
            offering = 1'b0;
         end
         if (!offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_events.size() != 0) begin
               offered_event = pending_events.pop_front();
               req_bus.device_is_keyboard <= offered_event.keyboard;
               req_bus.key_code           <= offered_event.code;
               req_bus.key_down           <= offered_event.down;
               offering = 1'b1;
               req_gap  = pick_pause(req_calm);
            end
         end
         req_bus.valid <= offering;
      end
   end

   // Result monitor: compare each result with the oldest prediction, then
   // stall for a random while.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_buttons.size() == 0) begin
               error_count++;
               $display("%0t: button_state unexpected, expected none, actual %h",
                        $time, rsp_bus.button_state);
            end else begin
               want_buttons = expected_buttons.pop_front();
               if (rsp_bus.button_state !== want_buttons) begin
                  error_count++;
                  $display("%0t: button_state mismatch, expected %h, actual %h",
                           $time, want_buttons, rsp_bus.button_state);
               end
            end
            rsp_stall = pick_pause(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: drop the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (psel && penable && pready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [kbldp_pkg::CSR_DATA_W-1:0] dir_word, act_word;
      logic [kbldp_pkg::KEY_CODE_W-1:0] start_word;

      req_bus.valid              = 1'b0;
      req_bus.device_is_keyboard = 1'b0;
      req_bus.key_code           = '0;
      req_bus.key_down           = 1'b0;
      rsp_bus.ready              = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the direction list to full depth, then unwind it: release the
      // newest, then one from the middle, then the rest, and release a key
      // that is no longer held. A repeated press must not reorder the list.
      queue_event(1'b1, button_key(UP_BTN), 1'b1);
      queue_event(1'b1, button_key(RIGHT_BTN), 1'b1);
      queue_event(1'b1, button_key(LEFT_BTN), 1'b1);
      queue_event(1'b1, button_key(DOWN_BTN), 1'b1);
      queue_event(1'b1, button_key(UP_BTN), 1'b1);
      queue_event(1'b1, button_key(DOWN_BTN), 1'b0);
      queue_event(1'b1, button_key(RIGHT_BTN), 1'b0);
      queue_event(1'b1, button_key(LEFT_BTN), 1'b0);
      queue_event(1'b1, button_key(UP_BTN), 1'b0);
      queue_event(1'b1, button_key(UP_BTN), 1'b0);
      // Hold every action button and start together.
      for (int b = A_BTN; b <= START_BTN; b++) queue_event(1'b1, button_key(b), 1'b1);
      // Ignore a non-keyboard press and unmapped codes at both extremes.
      queue_event(1'b0, button_key(UP_BTN), 1'b1);
      queue_event(1'b1, 8'h00, 1'b1);
      queue_event(1'b1, 8'hFF, 1'b1);
      for (int b = A_BTN; b <= START_BTN; b++) queue_event(1'b1, button_key(b), 1'b0);

      queue_random(RANDOM_PER_PHASE);
      wait_idle();

      // Step through settings: distinct codes, both all-ones/all-zeros
      // extremes (collisions where start and D win), crowded colliding codes,
      // fully random codes, and back to the defaults.
      for (int phase = 1; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1: begin
               dir_word = 32'h0302_0100; act_word = 32'h0706_0504; start_word = 8'h08;
            end
            2: begin
               dir_word = 32'hFFFF_FFFF; act_word = 32'h0000_0000; start_word = 8'hFF;
            end
            3: begin
               dir_word = 32'h0000_0000; act_word = 32'hFFFF_FFFF; start_word = 8'h00;
            end
            4, 5: begin
               dir_word   = crowded_codes();
               act_word   = crowded_codes();
               start_word = 8'h30 + 8'($urandom_range(0, 5));
            end
            6: begin
               dir_word = $urandom; act_word = $urandom; start_word = 8'($urandom);
            end
            default: begin
               dir_word   = kbldp_pkg::DIRECTION_KEYCODES_RESET;
               act_word   = kbldp_pkg::ACTION_KEYCODES_RESET;
               start_word = kbldp_pkg::START_KEYCODE_RESET;
            end
         endcase
         csr_write(kbldp_pkg::REG_DIRECTION_KEYCODES, dir_word);
         csr_write(kbldp_pkg::REG_ACTION_KEYCODES, act_word);
         csr_write(kbldp_pkg::REG_START_KEYCODE, {24'b0, start_word});
         queue_random(RANDOM_PER_PHASE);
         wait_idle();
      end

      // Give any stray result time to show up.
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
